@@ hdl/ibsa_pkg.sv @@
// Package: types, constants and state encoding for the pixel binning unit
package ibsa_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;

    localparam logic [CFG_INDEX_BITS-1:0] REG_X_START      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_START      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_WIDTH    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BIN_HEIGHT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AVERAGE_MODE = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_COLS     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_ROWS     = 3'd6;

    localparam logic STATUS_PIXEL  = 1'b0;
    localparam logic STATUS_BOUNDS = 1'b1;

    localparam int SCI_ACC_BITS = 48;
    localparam int ERR_ACC_BITS = 44;
    localparam int ROOT_BITS    = 22;
    localparam int AREA_BITS    = 13;
    localparam int COUNT_BITS   = 23;
    localparam int ROWS_LIMIT   = 4096;

    typedef struct packed {
        logic [11:0]        pix_col;
        logic [11:0]        pix_row;
        logic signed [31:0] sci_value;
        logic [15:0]        err_value;
        logic [15:0]        dq_value;
        logic               frame_end;
    } pix_in_t;

    typedef struct packed {
        logic [9:0]         out_col;
        logic [11:0]        out_row;
        logic signed [47:0] sci_out;
        logic [21:0]        err_out;
        logic [15:0]        dq_out;
        logic               status_code;
        logic               last_result;
    } bin_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_ACC,
        ST_SQRT,
        ST_DIV,
        ST_EMIT,
        ST_FEND,
        ST_STATUS
    } ctl_state_t;

    typedef struct packed {
        logic load_pixel;
        logic start_map;
        logic write_acc;
        logic start_sqrt;
        logic step_sqrt;
        logic start_div;
        logic step_div;
        logic emit_bin;
        logic emit_status;
        logic clear_count;
    } dp_cmd_t;

    typedef struct packed {
        logic clearing;
        logic map_done;
        logic in_bin;
        logic bin_done;
        logic sqrt_done;
        logic div_done;
        logic avg;
        logic frame_end;
        logic count_full;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ hdl/ibsa_ram.sv @@
// Generic single-port RAM with registered read
module ibsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

@@ hdl/ibsa_datapath.sv @@
// Datapath: coordinate mapping, line accumulators, root and area divide, output register
module ibsa_datapath #(
    parameter int MAX_OUT_COLS = 1024,
    parameter int MAX_BIN      = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ibsa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ibsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  ibsa_pkg::pix_in_t   pix_in,
    input  ibsa_pkg::dp_cmd_t   cmd,
    output ibsa_pkg::dp_stat_t  stat,
    output logic                m_valid,
    input  logic                m_ready,
    output ibsa_pkg::bin_out_t  m_data
);

    localparam int CB = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
    localparam int BB = $clog2(MAX_BIN + 1);
    localparam int DB = COORD_BITS;
    localparam int AB = ibsa_pkg::SCI_ACC_BITS;
    localparam int EB = ibsa_pkg::ERR_ACC_BITS;
    localparam int RB = ibsa_pkg::ROOT_BITS;
    localparam int KB = ibsa_pkg::COUNT_BITS;
    localparam int RWB = 13;

    // configuration
    logic [11:0] x_start_reg, y_start_reg;
    logic [6:0]  bin_width_reg, bin_height_reg;
    logic        avg_reg;
    logic [10:0] out_cols_reg;
    logic [12:0] out_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_start_reg    <= '0;
            y_start_reg    <= '0;
            bin_width_reg  <= 7'd1;
            bin_height_reg <= 7'd1;
            avg_reg        <= 1'b0;
            out_cols_reg   <= 11'd1;
            out_rows_reg   <= 13'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                ibsa_pkg::REG_X_START:      x_start_reg    <= cfg_data[11:0];
                ibsa_pkg::REG_Y_START:      y_start_reg    <= cfg_data[11:0];
                ibsa_pkg::REG_BIN_WIDTH:    bin_width_reg  <= cfg_data[6:0];
                ibsa_pkg::REG_BIN_HEIGHT:   bin_height_reg <= cfg_data[6:0];
                ibsa_pkg::REG_AVERAGE_MODE: avg_reg        <= cfg_data[0];
                ibsa_pkg::REG_OUT_COLS:     out_cols_reg   <= cfg_data[10:0];
                ibsa_pkg::REG_OUT_ROWS:     out_rows_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective limits
    logic [BB-1:0] bw, bh;
    logic [CB:0]   nc;
    logic [RWB-1:0] nr;
    logic [KB-1:0] total;

    always_comb begin
        if (bin_width_reg == '0) bw = BB'(1);
        else if (32'(bin_width_reg) > MAX_BIN) bw = BB'(MAX_BIN);
        else bw = BB'(bin_width_reg);
        if (bin_height_reg == '0) bh = BB'(1);
        else if (32'(bin_height_reg) > MAX_BIN) bh = BB'(MAX_BIN);
        else bh = BB'(bin_height_reg);
        if (out_cols_reg == '0) nc = (CB+1)'(1);
        else if (32'(out_cols_reg) > MAX_OUT_COLS) nc = (CB+1)'(MAX_OUT_COLS);
        else nc = (CB+1)'(out_cols_reg);
        if (out_rows_reg == '0) nr = RWB'(1);
        else nr = out_rows_reg[12] ? RWB'(ibsa_pkg::ROWS_LIMIT) : out_rows_reg;
    end

    // pixel capture
    ibsa_pkg::pix_in_t pix_reg;
    logic [DB-1:0] dx_reg, dy_reg;
    logic          inside_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_pixel) begin
            pix_reg    <= pix_in;
            inside_reg <= (pix_in.pix_col >= x_start_reg) && (pix_in.pix_row >= y_start_reg);
            dx_reg     <= DB'(pix_in.pix_col - x_start_reg);
            dy_reg     <= DB'(pix_in.pix_row - y_start_reg);
        end
    end

    // column / row mapping by repeated subtraction, one bin step per cycle
    logic [CB:0]    m_reg;
    logic [RWB-1:0] n_reg;
    logic [DB:0]    xr_reg, yr_reg;
    logic           in_bin_reg, map_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_done_reg <= 1'b0;
        end else if (cmd.start_map) begin
            m_reg        <= '0;
            n_reg        <= '0;
            xr_reg       <= (DB+1)'(dx_reg);
            yr_reg       <= (DB+1)'(dy_reg);
            in_bin_reg   <= inside_reg;
            map_done_reg <= !inside_reg;
        end else if (!map_done_reg) begin
            if (xr_reg >= (DB+1)'(bw)) begin
                xr_reg <= xr_reg - (DB+1)'(bw);
                m_reg  <= m_reg + 1'b1;
                if (m_reg + 1'b1 >= nc) begin
                    in_bin_reg   <= 1'b0;
                    map_done_reg <= 1'b1;
                end
            end else if (yr_reg >= (DB+1)'(bh)) begin
                yr_reg <= yr_reg - (DB+1)'(bh);
                n_reg  <= n_reg + 1'b1;
                if (n_reg + 1'b1 >= nr) begin
                    in_bin_reg   <= 1'b0;
                    map_done_reg <= 1'b1;
                end
            end else begin
                map_done_reg <= 1'b1;
            end
        end
    end

    logic first_px, last_px;
    assign first_px = (xr_reg == '0) && (yr_reg == '0);
    assign last_px  = (xr_reg == (DB+1)'(bw - 1'b1)) && (yr_reg == (DB+1)'(bh - 1'b1));

    // clearing pass after reset, one entry per cycle
    logic [CB-1:0] clr_addr_reg;
    logic          clr_busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == CB'(MAX_OUT_COLS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // line accumulators
    logic [AB-1:0] sci_rd, sci_wr, sci_ram_wd;
    logic [EB-1:0] err_rd, err_wr, err_ram_wd;
    logic [15:0]   dq_rd, dq_wr, dq_ram_wd;
    logic [CB-1:0] addr;
    logic          ram_we;
    logic [31:0]   sq;

    assign addr   = clr_busy_reg ? clr_addr_reg : CB'(m_reg);
    assign ram_we = clr_busy_reg || cmd.write_acc;
    assign sq   = 32'(pix_reg.err_value) * 32'(pix_reg.err_value);
    assign sci_wr = first_px ? AB'(pix_reg.sci_value) : sci_rd + AB'(pix_reg.sci_value);
    assign err_wr = first_px ? EB'(sq) : err_rd + EB'(sq);
    assign dq_wr  = first_px ? pix_reg.dq_value : (dq_rd | pix_reg.dq_value);
    assign sci_ram_wd = clr_busy_reg ? '0 : sci_wr;
    assign err_ram_wd = clr_busy_reg ? '0 : err_wr;
    assign dq_ram_wd  = clr_busy_reg ? '0 : dq_wr;

    ibsa_ram #(.WIDTH(AB), .DEPTH(MAX_OUT_COLS)) u_sci_ram (
        .aclk(aclk), .we(ram_we), .addr(addr), .wdata(sci_ram_wd), .rdata(sci_rd));
    ibsa_ram #(.WIDTH(EB), .DEPTH(MAX_OUT_COLS)) u_err_ram (
        .aclk(aclk), .we(ram_we), .addr(addr), .wdata(err_ram_wd), .rdata(err_rd));
    ibsa_ram #(.WIDTH(16), .DEPTH(MAX_OUT_COLS)) u_dq_ram (
        .aclk(aclk), .we(ram_we), .addr(addr), .wdata(dq_ram_wd), .rdata(dq_rd));

    logic [AB-1:0] bin_sci_reg;
    logic [15:0]   bin_dq_reg;

    always_ff @(posedge aclk) begin
        if (cmd.write_acc) begin
            bin_sci_reg <= sci_wr;
            bin_dq_reg  <= dq_wr;
        end
    end

    // integer square root, one result bit per cycle
    logic [EB-1:0] sq_rem_reg;
    logic [RB-1:0] root_reg;
    logic [EB-1:0] sq_val_reg;
    logic [4:0]    sq_cnt_reg;
    logic          sqrt_done_reg;
    logic [EB+1:0] trial_rem;
    logic [RB+1:0] trial;

    assign trial_rem = {sq_rem_reg, sq_val_reg[EB-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_done_reg <= 1'b0;
        end else if (cmd.start_sqrt) begin
            sq_val_reg    <= err_wr;
            sq_rem_reg    <= '0;
            root_reg      <= '0;
            sq_cnt_reg    <= 5'(RB);
            sqrt_done_reg <= 1'b0;
        end else if (cmd.step_sqrt && !sqrt_done_reg) begin
            sq_val_reg <= sq_val_reg << 2;
            if (trial_rem >= (EB+2)'(trial)) begin
                sq_rem_reg <= EB'(trial_rem - (EB+2)'(trial));
                root_reg   <= {root_reg[RB-2:0], 1'b1};
            end else begin
                sq_rem_reg <= EB'(trial_rem);
                root_reg   <= {root_reg[RB-2:0], 1'b0};
            end
            sq_cnt_reg    <= sq_cnt_reg - 1'b1;
            sqrt_done_reg <= (sq_cnt_reg == 5'd1);
        end
    end

    // area divide: restoring, signal magnitude and root in parallel
    localparam int NB = AB + 1;
    logic [ibsa_pkg::AREA_BITS+3:0] area;
    logic [NB-1:0]  sn_reg, sq_reg;
    logic [NB:0]    srem_reg;
    logic [RB:0]    en_reg, eq_reg;
    logic [RB+1:0]  erem_reg;
    logic           neg_reg, div_done_reg;
    logic [6:0]     div_cnt_reg;
    logic [NB:0]    s_try;
    logic [RB+1:0]  e_try;
    logic [AB-1:0]  mag;

    assign area = (ibsa_pkg::AREA_BITS+4)'(bw) * (ibsa_pkg::AREA_BITS+4)'(bh);
    assign mag  = bin_sci_reg[AB-1] ? AB'(-bin_sci_reg) : bin_sci_reg;
    assign s_try = {srem_reg[NB-1:0], sn_reg[NB-1]};
    assign e_try = {erem_reg[RB:0], en_reg[RB]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_done_reg <= 1'b0;
        end else if (cmd.start_div) begin
            neg_reg      <= bin_sci_reg[AB-1];
            sn_reg       <= NB'(mag) + NB'(area >> 1);
            en_reg       <= (RB+1)'(root_reg) + (RB+1)'(area >> 1);
            srem_reg     <= '0;
            erem_reg     <= '0;
            sq_reg       <= '0;
            eq_reg       <= '0;
            div_cnt_reg  <= 7'(NB);
            div_done_reg <= 1'b0;
        end else if (cmd.step_div && !div_done_reg) begin
            sn_reg <= sn_reg << 1;
            if (s_try >= (NB+1)'(area)) begin
                srem_reg <= s_try - (NB+1)'(area);
                sq_reg   <= {sq_reg[NB-2:0], 1'b1};
            end else begin
                srem_reg <= s_try;
                sq_reg   <= {sq_reg[NB-2:0], 1'b0};
            end
            if (div_cnt_reg <= 7'(RB + 1)) begin
                en_reg <= en_reg << 1;
                if (e_try >= (RB+2)'(area)) begin
                    erem_reg <= e_try - (RB+2)'(area);
                    eq_reg   <= {eq_reg[RB-1:0], 1'b1};
                end else begin
                    erem_reg <= e_try;
                    eq_reg   <= {eq_reg[RB-1:0], 1'b0};
                end
            end
            div_cnt_reg  <= div_cnt_reg - 1'b1;
            div_done_reg <= (div_cnt_reg == 7'd1);
        end
    end

    // bins completed
    logic [KB-1:0] count_reg, count_inc;
    assign total     = KB'(nc) * KB'(nr);
    assign count_inc = count_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.clear_count) begin
            count_reg <= '0;
        end else if (cmd.emit_bin) begin
            count_reg <= count_inc;
        end
    end

    // output register
    logic m_valid_reg;
    ibsa_pkg::bin_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_bin || cmd.emit_status) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_bin) begin
            m_data_reg.out_col     <= 10'(m_reg);
            m_data_reg.out_row     <= 12'(n_reg);
            m_data_reg.sci_out     <= avg_reg ? (neg_reg ? AB'(-sq_reg) : AB'(sq_reg))
                                              : bin_sci_reg;
            m_data_reg.err_out     <= avg_reg ? RB'(eq_reg) : root_reg;
            m_data_reg.dq_out      <= bin_dq_reg;
            m_data_reg.status_code <= ibsa_pkg::STATUS_PIXEL;
            m_data_reg.last_result <= (count_inc == total);
        end else if (cmd.emit_status) begin
            m_data_reg.out_col     <= '0;
            m_data_reg.out_row     <= '0;
            m_data_reg.sci_out     <= '0;
            m_data_reg.err_out     <= '0;
            m_data_reg.dq_out      <= '0;
            m_data_reg.status_code <= ibsa_pkg::STATUS_BOUNDS;
            m_data_reg.last_result <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign stat.clearing   = clr_busy_reg;
    assign stat.map_done   = map_done_reg;
    assign stat.in_bin     = in_bin_reg;
    assign stat.bin_done   = last_px;
    assign stat.sqrt_done  = sqrt_done_reg;
    assign stat.div_done   = div_done_reg;
    assign stat.avg        = avg_reg;
    assign stat.frame_end  = pix_reg.frame_end;
    assign stat.count_full = (count_reg == total);
    assign stat.out_busy   = m_valid_reg && !m_ready;

endmodule

@@ hdl/ibsa_ctrl.sv @@
// Controller: sequences one pixel transaction through the datapath
module ibsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ibsa_pkg::dp_stat_t stat,
    output ibsa_pkg::dp_cmd_t  cmd
);

    ibsa_pkg::ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ibsa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ibsa_pkg::ST_IDLE: begin
                s_ready = !stat.clearing;
                if (s_valid && !stat.clearing) begin
                    cmd.load_pixel = 1'b1;
                    state_next     = ibsa_pkg::ST_MAP;
                end
            end
            ibsa_pkg::ST_MAP: begin
                cmd.start_map = 1'b1;
                state_next    = ibsa_pkg::ST_READ;
            end
            ibsa_pkg::ST_READ: begin
                if (stat.map_done) begin
                    state_next = stat.in_bin ? ibsa_pkg::ST_ACC : ibsa_pkg::ST_FEND;
                end
            end
            ibsa_pkg::ST_ACC: begin
                cmd.write_acc = 1'b1;
                if (stat.bin_done) begin
                    cmd.start_sqrt = 1'b1;
                    state_next     = ibsa_pkg::ST_SQRT;
                end else begin
                    state_next = ibsa_pkg::ST_FEND;
                end
            end
            ibsa_pkg::ST_SQRT: begin
                cmd.step_sqrt = 1'b1;
                if (stat.sqrt_done) begin
                    cmd.start_div = 1'b1;
                    state_next    = stat.avg ? ibsa_pkg::ST_DIV : ibsa_pkg::ST_EMIT;
                end
            end
            ibsa_pkg::ST_DIV: begin
                cmd.step_div = 1'b1;
                if (stat.div_done) begin
                    state_next = ibsa_pkg::ST_EMIT;
                end
            end
            ibsa_pkg::ST_EMIT: begin
                if (!stat.out_busy) begin
                    cmd.emit_bin = 1'b1;
                    state_next   = ibsa_pkg::ST_FEND;
                end
            end
            ibsa_pkg::ST_FEND: begin
                if (!stat.frame_end) begin
                    state_next = ibsa_pkg::ST_IDLE;
                end else if (stat.count_full) begin
                    cmd.clear_count = 1'b1;
                    state_next      = ibsa_pkg::ST_IDLE;
                end else begin
                    state_next = ibsa_pkg::ST_STATUS;
                end
            end
            ibsa_pkg::ST_STATUS: begin
                if (!stat.out_busy) begin
                    cmd.emit_status = 1'b1;
                    cmd.clear_count = 1'b1;
                    state_next      = ibsa_pkg::ST_IDLE;
                end
            end
            default: state_next = ibsa_pkg::ST_IDLE;
        endcase
    end

endmodule

@@ hdl/image_bin_sum_average_unit.sv @@
// Top level of the pixel binning unit with error propagation
// Per pixel: the controller loads the pixel, maps it to an output column and row and, for a
// pixel inside a bin, accumulates it; a bin end adds the root and the output load, plus the
// area divide in average mode; a frame end may add a status; waiting outputs stall.
// Throughput: one pixel transaction at a time; s_ready is high only while idle.
// Reset: synchronous active-low aresetn clears control, registers and the bin count, then a
// pass zeroes the accumulator lines while s_ready stays low.
module image_bin_sum_average_unit #(
    parameter int MAX_OUT_COLS = 1024,
    parameter int MAX_BIN      = 64,
    parameter int COORD_BITS   = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [ibsa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ibsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  ibsa_pkg::pix_in_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ibsa_pkg::bin_out_t  m_data
);

    ibsa_pkg::dp_cmd_t  cmd;
    ibsa_pkg::dp_stat_t stat;

    ibsa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .stat(stat), .cmd(cmd));

    ibsa_datapath #(
        .MAX_OUT_COLS(MAX_OUT_COLS), .MAX_BIN(MAX_BIN), .COORD_BITS(COORD_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix_in(s_data), .cmd(cmd), .stat(stat),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));

endmodule

@@ tb/sv/ibsa_checker.sv @@
// Checker for the pixel binning unit: predicts bin results and compares them
`timescale 1ns / 1ps
module ibsa_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ibsa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ibsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  ibsa_pkg::pix_in_t                   s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  ibsa_pkg::bin_out_t                  m_data,
    output int                                  mismatches,
    output int                                  pending
);

    localparam int MAX_BIN_C = 64;

    logic [11:0] x0, y0;
    logic [6:0]  bin_w, bin_h;
    logic        avg_on;
    logic [10:0] n_cols;
    logic [12:0] n_rows;
    logic [22:0] bins_done;

    longint          sig_line [1024];
    longint unsigned sq_line  [1024];
    logic [15:0]     dq_line  [1024];

    ibsa_pkg::bin_out_t expected_bins[$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic int eff(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - r - b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_pixel(ibsa_pkg::pix_in_t p);
        int bw, bh, nc, nr, dx, dy, m, n, bx, by;
        int unsigned total;
        longint s, sv;
        longint unsigned e, sq, area, mag, q;
        ibsa_pkg::bin_out_t r;
        bw = eff(bin_w, MAX_BIN_C);
        bh = eff(bin_h, MAX_BIN_C);
        nc = eff(n_cols, 1024);
        nr = eff(n_rows, ibsa_pkg::ROWS_LIMIT);
        total = nc * nr;
        if (p.pix_col >= x0 && p.pix_row >= y0) begin
            dx = p.pix_col - x0;
            dy = p.pix_row - y0;
            if (dx < nc * bw && dy < nr * bh) begin
                m = dx / bw; bx = dx % bw;
                n = dy / bh; by = dy % bh;
                sq = longint'(p.err_value) * longint'(p.err_value);
                if (bx == 0 && by == 0) begin
                    sig_line[m] = longint'(p.sci_value);
                    sq_line[m]  = sq;
                    dq_line[m]  = p.dq_value;
                end else begin
                    sig_line[m] += longint'(p.sci_value);
                    sq_line[m]  += sq;
                    dq_line[m]  |= p.dq_value;
                end
                if (bx == bw - 1 && by == bh - 1) begin
                    s = sig_line[m];
                    e = root_floor(sq_line[m]);
                    if (avg_on) begin
                        area = bw * bh;
                        mag  = (s < 0) ? -s : s;
                        q    = (mag + area / 2) / area;
                        sv   = (s < 0) ? -longint'(q) : longint'(q);
                        e    = (e + area / 2) / area;
                    end else begin
                        sv = s;
                    end
                    bins_done     = bins_done + 1;
                    r             = '0;
                    r.out_col     = m[9:0];
                    r.out_row     = n[11:0];
                    r.sci_out     = sv[47:0];
                    r.err_out     = e[21:0];
                    r.dq_out      = dq_line[m];
                    r.status_code = ibsa_pkg::STATUS_PIXEL;
                    r.last_result = (bins_done == total);
                    expected_bins.push_back(r);
                end
            end
        end
        if (p.frame_end) begin
            if (bins_done != total) begin
                r             = '0;
                r.status_code = ibsa_pkg::STATUS_BOUNDS;
                r.last_result = 1'b1;
                expected_bins.push_back(r);
            end
            bins_done = '0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic compare_bin(ibsa_pkg::bin_out_t got);
        ibsa_pkg::bin_out_t want;
        if (expected_bins.size() == 0) begin
            report_mismatch("unexpected result transaction count", 1, 0);
            return;
        end
        want = expected_bins.pop_front();
        if (got.out_col !== want.out_col)
            report_mismatch("out_col", got.out_col, want.out_col);
        if (got.out_row !== want.out_row)
            report_mismatch("out_row", got.out_row, want.out_row);
        if (got.sci_out !== want.sci_out)
            report_mismatch("sci_out", got.sci_out, want.sci_out);
        if (got.err_out !== want.err_out)
            report_mismatch("err_out", got.err_out, want.err_out);
        if (got.dq_out !== want.dq_out)
            report_mismatch("dq_out", got.dq_out, want.dq_out);
        if (got.status_code !== want.status_code)
            report_mismatch("status_code", got.status_code, want.status_code);
        if (got.last_result !== want.last_result)
            report_mismatch("last_result", got.last_result, want.last_result);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            x0 = '0; y0 = '0;
            bin_w = 7'd1; bin_h = 7'd1;
            avg_on = 1'b0;
            n_cols = 11'd1; n_rows = 13'd1;
            bins_done = '0;
            for (int k = 0; k < 1024; k++) begin
                sig_line[k] = 0;
                sq_line[k]  = 0;
                dq_line[k]  = '0;
            end
            expected_bins.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ibsa_pkg::REG_X_START:      x0     = cfg_data[11:0];
                    ibsa_pkg::REG_Y_START:      y0     = cfg_data[11:0];
                    ibsa_pkg::REG_BIN_WIDTH:    bin_w  = cfg_data[6:0];
                    ibsa_pkg::REG_BIN_HEIGHT:   bin_h  = cfg_data[6:0];
                    ibsa_pkg::REG_AVERAGE_MODE: avg_on = cfg_data[0];
                    ibsa_pkg::REG_OUT_COLS:     n_cols = cfg_data[10:0];
                    ibsa_pkg::REG_OUT_ROWS:     n_rows = cfg_data[12:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_pixel(s_data);
            if (m_valid && m_ready)
                compare_bin(m_data);
        end
        pending = expected_bins.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the pixel binning unit: stimulus, handshakes and verdict
`timescale 1ns / 1ps
module tb_top;

    localparam int IDLE_LIMIT = 100000;
    localparam int ITEM_GOAL  = 2000;

    logic                                aclk;
    logic                                aresetn;
    logic                                cfg_we;
    logic [ibsa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ibsa_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                                s_valid;
    logic                                s_ready;
    ibsa_pkg::pix_in_t                   s_data;
    logic                                m_valid;
    logic                                m_ready;
    ibsa_pkg::bin_out_t                  m_data;
    int                                  mismatches;
    int                                  pending;

    int xs, ys, bw, bh, nc, nr, raw_nc, raw_nr;
    int items_sent;
    int burst_left;
    int idle_cycles;
    bit start_hold;
    bit hold_done;
    int hold_left;
    int ptn_left;
    int ptn_mode;
    logic [23:0] visited[$];

    image_bin_sum_average_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    ibsa_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver: random stall pattern plus one long hold-off
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        ptn_left  = 0;
        ptn_mode  = 0;
    end

    always @(posedge aclk) begin
        if (start_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 3000;
        end
        if (ptn_left == 0) begin
            ptn_mode = $urandom_range(0, 2);
            ptn_left = $urandom_range(20, 300);
        end
        ptn_left--;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (ptn_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 1) == 0);
                default: m_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** image_bin_sum_average_unit: FAILED **");
        $finish;
    end

    function automatic int clampv(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic set_reg(logic [ibsa_pkg::CFG_INDEX_BITS-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[ibsa_pkg::CFG_DATA_BITS-1:0];
        @(posedge aclk);
    endtask

    task automatic configure(int x, int y, int w, int h, int avg, int c, int r);
        @(posedge aclk);
        set_reg(ibsa_pkg::REG_X_START, x);
        set_reg(ibsa_pkg::REG_Y_START, y);
        set_reg(ibsa_pkg::REG_BIN_WIDTH, w);
        set_reg(ibsa_pkg::REG_BIN_HEIGHT, h);
        set_reg(ibsa_pkg::REG_AVERAGE_MODE, avg);
        set_reg(ibsa_pkg::REG_OUT_COLS, c);
        set_reg(ibsa_pkg::REG_OUT_ROWS, r);
        cfg_we <= 1'b0;
        xs = x & 12'hFFF;
        ys = y & 12'hFFF;
        bw = clampv(w & 7'h7F, 64);
        bh = clampv(h & 7'h7F, 64);
        raw_nc = c & 11'h7FF;
        raw_nr = r & 13'h1FFF;
        nc = clampv(raw_nc, 1024);
        nr = clampv(raw_nr, 4096);
        visited.delete();
    endtask

    // drop valid, wait for every expected result, then let the mapping loop finish
    task automatic quiesce();
        s_valid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        wait (pending == 0);
        repeat (4 + raw_nc + raw_nr + 100) @(posedge aclk);
    endtask

    task automatic send_pixel(ibsa_pkg::pix_in_t p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    function automatic ibsa_pkg::pix_in_t make_pixel(int c, int r, bit fe);
        ibsa_pkg::pix_in_t p;
        p.pix_col = c[11:0];
        p.pix_row = r[11:0];
        case ($urandom_range(0, 7))
            0: p.sci_value = 32'sh8000_0000;
            1: p.sci_value = 32'sh7FFF_FFFF;
            2: p.sci_value = $urandom_range(0, 3) - 2;
            default: p.sci_value = $urandom;
        endcase
        p.err_value = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        p.dq_value  = ($urandom_range(0, 15) == 0) ? 16'h0 : 16'($urandom);
        p.frame_end = fe;
        return p;
    endfunction

    // raster frame over the subarray plus a one-pixel margin, optionally cut short
    task automatic run_frame(bit cut);
        int c0, c1, r0, r1, total, stop_at, idx, pick;
        bit fe;
        c0 = (xs > 0) ? xs - 1 : xs;
        r0 = (ys > 0) ? ys - 1 : ys;
        c1 = (xs + nc * bw > 4095) ? 4095 : xs + nc * bw;
        r1 = (ys + nr * bh > 4095) ? 4095 : ys + nr * bh;
        total   = (c1 - c0 + 1) * (r1 - r0 + 1);
        stop_at = cut ? $urandom_range(1, total) : total;
        idx = 0;
        for (int r = r0; r <= r1 && idx < stop_at; r++) begin
            for (int c = c0; c <= c1 && idx < stop_at; c++) begin
                idx++;
                fe = (idx == stop_at);
                send_pixel(make_pixel(c, r, fe));
                if (c >= xs && r >= ys && c < xs + nc * bw && r < ys + nr * bh)
                    visited.push_back({c[11:0], r[11:0]});
                // out-of-order revisit of an entry already loaded
                if (!fe && visited.size() > 0 && $urandom_range(0, 49) == 0) begin
                    pick = $urandom_range(0, visited.size() - 1);
                    send_pixel(make_pixel(visited[pick][23:12], visited[pick][11:0], 1'b0));
                end
            end
        end
    endtask

    task automatic random_phase(int phase);
        int w, h, c, r, ext_x, ext_y, wr, hr, cr, rr, frames;
        case (phase % 12)
            0: begin w = 64; h = 1; c = 1; r = 1; end
            6: begin w = 1; h = 64; c = 1; r = 1; end
            default: begin
                w = $urandom_range(1, 4); h = $urandom_range(1, 4);
                c = $urandom_range(1, 4); r = $urandom_range(1, 4);
            end
        endcase
        ext_x = c * w;
        ext_y = r * h;
        wr = (w == 1 && $urandom_range(0, 3) == 0) ? 0 :
             (w == 64 && $urandom_range(0, 1) == 0) ? $urandom_range(65, 127) : w;
        hr = (h == 1 && $urandom_range(0, 3) == 0) ? 0 :
             (h == 64 && $urandom_range(0, 1) == 0) ? $urandom_range(65, 127) : h;
        cr = (c == 1 && $urandom_range(0, 3) == 0) ? 0 : c;
        rr = (r == 1 && $urandom_range(0, 3) == 0) ? 0 : r;
        if ($urandom_range(0, 9) == 0)
            configure($urandom_range(4096 - ext_x, 4095), $urandom_range(4096 - ext_y, 4095),
                      wr, hr, $urandom_range(0, 1), cr, rr);
        else
            configure($urandom_range(0, 4095 - ext_x), $urandom_range(0, 4095 - ext_y),
                      wr, hr, $urandom_range(0, 1), cr, rr);
        frames = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++)
            run_frame($urandom_range(0, 4) == 0);
        quiesce();
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        start_hold = 1'b0;
        items_sent = 0;
        burst_left = 0;
        xs = 0; ys = 0; bw = 1; bh = 1; nc = 1; nr = 1; raw_nc = 1; raw_nr = 1;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: single-pixel bins, extremes of the data fields
        send_pixel(make_pixel(0, 0, 1'b0));
        send_pixel('{12'd0, 12'd0, 32'sh8000_0000, 16'hFFFF, 16'hFFFF, 1'b1});
        send_pixel('{12'd5, 12'd5, 32'sh7FFF_FFFF, 16'h0, 16'h0, 1'b1});
        send_pixel('{12'd0, 12'd0, 32'sh7FFF_FFFF, 16'h0, 16'h0, 1'b0});
        send_pixel('{12'd1, 12'd1, 32'sh0, 16'h1, 16'h1, 1'b1});
        quiesce();

        // rounding ties in average mode, second bin past the count
        configure(0, 0, 2, 1, 1, 1, 1);
        send_pixel('{12'd0, 12'd0, 32'sh1, 16'h1, 16'h8000, 1'b0});
        send_pixel('{12'd1, 12'd0, 32'sh0, 16'h2, 16'h0001, 1'b0});
        send_pixel('{12'd0, 12'd0, -32'sh1, 16'h3, 16'h0, 1'b0});
        send_pixel('{12'd1, 12'd0, 32'sh0, 16'h0, 16'h0, 1'b1});
        quiesce();

        // register encodings beyond the limits, largest output grid
        configure(0, 0, 0, 0, 0, 2047, 8191);
        send_pixel(make_pixel(1023, 4095, 1'b0));
        send_pixel(make_pixel(1024, 4095, 1'b0));
        send_pixel(make_pixel(4095, 0, 1'b1));
        quiesce();
        configure(4095, 4095, 127, 127, 1, 1024, 4096);
        send_pixel(make_pixel(4094, 4095, 1'b0));
        send_pixel(make_pixel(4095, 4095, 1'b1));
        quiesce();
        configure(4095, 4095, 1, 1, 0, 1, 1);
        send_pixel(make_pixel(4095, 4094, 1'b0));
        send_pixel(make_pixel(4095, 4095, 1'b1));
        quiesce();

        for (int phase = 0; items_sent < ITEM_GOAL; phase++) begin
            if (phase == 3)
                start_hold = 1'b1;
            random_phase(phase);
        end

        @(negedge aclk);
        wait (pending == 0);
        repeat (4 + raw_nc + raw_nr + 100) @(posedge aclk);
        if (mismatches == 0 && pending == 0)
            $display("** image_bin_sum_average_unit: PASSED **");
        else
            $display("** image_bin_sum_average_unit: FAILED **");
        $finish;
    end

endmodule
